FILE: hdl/visibility_edge_length_histogram_assert.svh
// Assertion macros shared by the histogram block.
`ifndef VISIBILITY_EDGE_LENGTH_HISTOGRAM_ASSERT_SVH
`define VISIBILITY_EDGE_LENGTH_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VELH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("velh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VELH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("velh assertion failed");

`endif

FILE: hdl/velh_pkg.sv
package velh_pkg;

    // Series storage.
    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Result field widths.
    localparam int BIN_W = 6;
    localparam int GAP_W = 7;

    // Cross-multiplied visibility test: sample difference times a distance.
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + CNT_W + 1;

    // One histogram bin written by the visibility pass.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BIN_W-1:0]  count;
    } t_hist_wr;

    // End of a visibility pass.
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] n;
        logic [GAP_W-1:0] gap;
    } t_scan_done;

endpackage

FILE: hdl/velh_scan.sv
module velh_scan (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [velh_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic [velh_pkg::SAMPLE_BITS-1:0]   i_wr_data,
    input  logic                               i_start,
    input  logic [velh_pkg::CNT_W-1:0]         i_n,
    output logic                               o_busy,
    output velh_pkg::t_hist_wr                 o_hist_wr,
    output velh_pkg::t_scan_done               o_done
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAIR = 6'b000010,
        S_RDA  = 6'b000100,
        S_RDB  = 6'b001000,
        S_MUL  = 6'b010000,
        S_CMP  = 6'b100000
    } t_scan_state;

    t_scan_state r_state, n_state;

    logic [velh_pkg::SAMPLE_BITS-1:0] r_sample_mem [velh_pkg::MAX_SAMPLES];
    logic [velh_pkg::SAMPLE_BITS-1:0] r_rd_data;
    logic [velh_pkg::ADDR_W-1:0]      w_rd_addr;

    logic [velh_pkg::CNT_W-1:0]  r_n;
    logic [velh_pkg::CNT_W-1:0]  r_d;
    logic [velh_pkg::ADDR_W-1:0] r_a;
    logic [velh_pkg::ADDR_W-1:0] r_c;
    logic [velh_pkg::BIN_W-1:0]  r_cnt;
    logic [velh_pkg::GAP_W-1:0]  r_gap;
    logic                        r_found;
    logic [velh_pkg::SAMPLE_BITS-1:0] r_ya;
    logic [velh_pkg::SAMPLE_BITS-1:0] r_yb;
    logic signed [velh_pkg::PROD_W-1:0] r_lhs;
    logic signed [velh_pkg::PROD_W-1:0] r_rhs;

    logic [velh_pkg::ADDR_W-1:0] w_b;
    logic                        w_pair_ok;
    logic                        w_gap_hit;
    logic                        w_last_c;
    logic                        w_blocked;
    logic signed [velh_pkg::DIFF_W-1:0]  w_dc;
    logic signed [velh_pkg::DIFF_W-1:0]  w_dab;
    logic signed [velh_pkg::CNT_W:0]     w_span;
    logic signed [velh_pkg::CNT_W:0]     w_bmc;

    // Pair geometry for the current distance and left end.
    assign w_b       = r_a + r_d[velh_pkg::ADDR_W-1:0];
    assign w_pair_ok = (r_d >= velh_pkg::CNT_W'(2)) &&
                       ((velh_pkg::CNT_W'(r_a) + r_d) < r_n);
    assign w_gap_hit = (r_d >= velh_pkg::CNT_W'(2)) && (r_cnt == '0) && !r_found;
    assign w_last_c  = (r_c + velh_pkg::ADDR_W'(1)) == w_b;
    assign w_blocked = r_lhs >= r_rhs;

    // Differences and distances for the cross-multiplied test.
    assign w_dc   = velh_pkg::DIFF_W'($signed(r_rd_data)) - velh_pkg::DIFF_W'($signed(r_yb));
    assign w_dab  = velh_pkg::DIFF_W'($signed(r_ya)) - velh_pkg::DIFF_W'($signed(r_yb));
    assign w_span = $signed({1'b0, r_d});
    assign w_bmc  = $signed({{(velh_pkg::CNT_W + 1 - velh_pkg::ADDR_W){1'b0}}, w_b - r_c});

    // Sample memory: one write port for loading, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sample_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_sample_mem[w_rd_addr];
    end

    // Read address issued in each state; the read data is registered and is back in the next cycle.
    always_comb begin
        unique case (r_state)
            S_RDA:   w_rd_addr = w_b;
            S_RDB:   w_rd_addr = r_a + velh_pkg::ADDR_W'(1);
            S_CMP:   w_rd_addr = r_c + velh_pkg::ADDR_W'(1);
            default: w_rd_addr = r_a;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_PAIR;
            S_PAIR: begin
                if (w_pair_ok) begin
                    n_state = S_RDA;
                end else if (r_d == r_n) begin
                    n_state = S_IDLE;
                end
            end
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_MUL;
            S_MUL:  n_state = S_CMP;
            S_CMP: begin
                if (w_blocked || w_last_c) begin
                    n_state = S_PAIR;
                end else begin
                    n_state = S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pass counters and the per-distance pair count.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n     <= i_n;
                r_d     <= velh_pkg::CNT_W'(1);
                r_a     <= '0;
                r_cnt   <= '0;
                r_found <= 1'b0;
                r_gap   <= velh_pkg::GAP_W'(i_n) + velh_pkg::GAP_W'(1);
            end
            S_PAIR: begin
                if (!w_pair_ok) begin
                    if (w_gap_hit) begin
                        r_gap   <= velh_pkg::GAP_W'(r_d);
                        r_found <= 1'b1;
                    end
                    r_d   <= r_d + velh_pkg::CNT_W'(1);
                    r_a   <= '0;
                    r_cnt <= '0;
                end
            end
            S_RDA: r_ya <= r_rd_data;
            S_RDB: begin
                r_yb <= r_rd_data;
                r_c  <= r_a + velh_pkg::ADDR_W'(1);
            end
            S_MUL: begin
                r_lhs <= velh_pkg::PROD_W'(w_dc * w_span);
                r_rhs <= velh_pkg::PROD_W'(w_dab * w_bmc);
            end
            S_CMP: begin
                if (w_blocked) begin
                    r_a <= r_a + velh_pkg::ADDR_W'(1);
                end else if (w_last_c) begin
                    r_a   <= r_a + velh_pkg::ADDR_W'(1);
                    r_cnt <= r_cnt + velh_pkg::BIN_W'(1);
                end else begin
                    r_c <= r_c + velh_pkg::ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Each distance finishes with one bin write; the pass ends at distance n.
    assign o_busy          = (r_state != S_IDLE);
    assign o_hist_wr.en    = (r_state == S_PAIR) && !w_pair_ok;
    assign o_hist_wr.addr  = r_d[velh_pkg::ADDR_W-1:0] - velh_pkg::ADDR_W'(1);
    assign o_hist_wr.count = r_cnt;
    assign o_done.done     = (r_state == S_PAIR) && !w_pair_ok && (r_d == r_n);
    assign o_done.n        = r_n;
    assign o_done.gap      = w_gap_hit ? velh_pkg::GAP_W'(r_d) : r_gap;

endmodule

FILE: hdl/velh_emit.sv
module velh_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  velh_pkg::t_hist_wr             i_hist_wr,
    input  velh_pkg::t_scan_done           i_done,
    input  logic                           i_ready,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [velh_pkg::BIN_W-1:0]     o_bin_index,
    output logic [velh_pkg::BIN_W-1:0]     o_bin_count,
    output logic [velh_pkg::GAP_W-1:0]     o_first_gap,
    output logic                           o_last_bin
);

    logic [velh_pkg::BIN_W-1:0]  r_hist_mem [velh_pkg::MAX_SAMPLES];
    logic [velh_pkg::BIN_W-1:0]  r_rd_data;

    logic                        r_busy;
    logic                        r_inflight;
    logic [velh_pkg::CNT_W-1:0]  r_idx;
    logic [velh_pkg::ADDR_W-1:0] r_ld_idx;
    logic [velh_pkg::CNT_W-1:0]  r_n;
    logic [velh_pkg::GAP_W-1:0]  r_gap;
    logic                        r_out_valid;
    logic [velh_pkg::BIN_W-1:0]  r_out_index;
    logic [velh_pkg::BIN_W-1:0]  r_out_count;
    logic                        r_out_last;

    logic w_take;
    logic w_issue;

    assign w_take  = r_out_valid && i_ready;
    assign w_issue = r_busy && !r_inflight && (r_idx < r_n) && (!r_out_valid || i_ready);

    // Histogram memory: written by the pass, read in bin order here.
    always_ff @(posedge i_clk) begin
        if (i_hist_wr.en) begin
            r_hist_mem[i_hist_wr.addr] <= i_hist_wr.count;
        end
        r_rd_data <= r_hist_mem[r_idx[velh_pkg::ADDR_W-1:0]];
    end

    // Read sequencing; a read is issued only when the output register is free next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_inflight  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_done.done) begin
                r_busy <= 1'b1;
            end else if (w_take && r_out_last) begin
                r_busy <= 1'b0;
            end
            r_inflight <= w_issue;
            if (r_inflight) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Bin counter and result payload.
    always_ff @(posedge i_clk) begin
        if (i_done.done) begin
            r_idx <= '0;
            r_n   <= i_done.n;
            r_gap <= i_done.gap;
        end else if (w_issue) begin
            r_idx    <= r_idx + velh_pkg::CNT_W'(1);
            r_ld_idx <= r_idx[velh_pkg::ADDR_W-1:0];
        end
        if (r_inflight) begin
            r_out_index <= velh_pkg::BIN_W'(r_ld_idx);
            r_out_count <= r_rd_data;
            r_out_last  <= (velh_pkg::CNT_W'(r_ld_idx) + velh_pkg::CNT_W'(1)) == r_n;
        end
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_out_valid;
    assign o_bin_index = r_out_index;
    assign o_bin_count = r_out_count;
    assign o_first_gap = r_gap;
    assign o_last_bin  = r_out_last;

endmodule

FILE: hdl/visibility_edge_length_histogram.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------------
// input    | i_valid / o_ready  | i_sample[15:0], i_final_sample
// output   | o_valid / i_ready  | o_bin_index[5:0], o_bin_count[5:0], o_first_gap[6:0],
//          |                    | o_last_bin
//
// Samples load one per cycle into the sample memory while o_ready is high; a sample beyond
// the 64th is dropped. After the flagged sample the visibility pass runs with o_ready low:
// a check per distance, registered reads of both ends per pair, and a registered multiply
// and a compare per tested middle sample. Bins then leave in order, one read at a time.
// A series may load during delivery; its flagged sample holds o_ready low until its pass ends.
// Reset is synchronous, active low.
`include "visibility_edge_length_histogram_assert.svh"

module visibility_edge_length_histogram (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [velh_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic                               i_final_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [velh_pkg::BIN_W-1:0]         o_bin_index,
    output logic [velh_pkg::BIN_W-1:0]         o_bin_count,
    output logic [velh_pkg::GAP_W-1:0]         o_first_gap,
    output logic                               o_last_bin
);

    logic [velh_pkg::CNT_W-1:0] r_count;
    logic                       r_pend;
    logic [velh_pkg::CNT_W-1:0] r_pend_n;

    logic                       w_accept;
    logic                       w_room;
    logic [velh_pkg::CNT_W-1:0] w_n_after;
    logic                       w_start_now;
    logic                       w_start_pend;
    logic                       w_scan_busy;
    logic                       w_emit_busy;
    logic [velh_pkg::GAP_W-1:0] w_gap_max;
    velh_pkg::t_hist_wr         w_hist_wr;
    velh_pkg::t_scan_done       w_done;

    // Input transaction and the series length it leaves.
    assign w_accept     = i_valid && o_ready;
    assign w_room       = r_count < velh_pkg::CNT_W'(velh_pkg::MAX_SAMPLES);
    assign w_n_after    = w_room ? (r_count + velh_pkg::CNT_W'(1)) : r_count;
    assign w_start_now  = w_accept && i_final_sample && !w_emit_busy;
    assign w_start_pend = r_pend && !w_emit_busy && !w_scan_busy;
    assign o_ready      = !w_scan_busy && !r_pend;

    // Sample count of the series being loaded, and a held start while bins drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= i_final_sample ? '0 : w_n_after;
            end
            if (w_accept && i_final_sample && w_emit_busy) begin
                r_pend <= 1'b1;
            end else if (w_start_pend) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_final_sample) begin
            r_pend_n <= w_n_after;
        end
    end

    velh_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept && w_room),
        .i_wr_addr (r_count[velh_pkg::ADDR_W-1:0]),
        .i_wr_data (i_sample),
        .i_start   (w_start_now || w_start_pend),
        .i_n       (w_start_pend ? r_pend_n : w_n_after),
        .o_busy    (w_scan_busy),
        .o_hist_wr (w_hist_wr),
        .o_done    (w_done)
    );

    velh_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hist_wr   (w_hist_wr),
        .i_done      (w_done),
        .i_ready     (i_ready),
        .o_busy      (w_emit_busy),
        .o_valid     (o_valid),
        .o_bin_index (o_bin_index),
        .o_bin_count (o_bin_count),
        .o_first_gap (o_first_gap),
        .o_last_bin  (o_last_bin)
    );

    // Largest first gap a series can report, taken from its last bin.
    assign w_gap_max = velh_pkg::GAP_W'(o_bin_index) + velh_pkg::GAP_W'(2);

    // No result is shown while the histogram is being rebuilt.
    `VELH_ASSERT_NOW(a_no_output_in_scan, i_clk, i_rst_n, w_scan_busy, !o_valid)
    // Adjacent samples are never counted.
    `VELH_ASSERT_NOW(a_bin0_zero, i_clk, i_rst_n, o_valid && (o_bin_index == '0), o_bin_count == '0)
    // The first gap never lies beyond the series length plus one.
    `VELH_ASSERT_NOW(a_gap_bound, i_clk, i_rst_n, o_valid && o_last_bin, o_first_gap <= w_gap_max)
    // A finished pass always hands over to delivery.
    `VELH_ASSERT_NEXT(a_done_to_emit, i_clk, i_rst_n, w_done.done, w_emit_busy && !w_scan_busy)

endmodule
